[rtl/core/vgg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgg_pkg
// Shared types, register codes and reset values of the vector glyph generator.
// ----------------------------------------------------------------------------
package vgg_pkg;

	// grid size defaults
	localparam int GRID_ROWS_DEF = 64;
	localparam int GRID_COLS_DEF = 64;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// configuration port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register reset values
	localparam logic [14:0] LIMIT_RST     = 15'd256;
	localparam logic [23:0] CELL_SIZE_RST = 24'd65536;
	localparam logic [23:0] SLOW_RST      = 24'h0000FF;
	localparam logic [23:0] FAST_RST      = 24'hFF0000;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIMIT     = 3'd0,
		CFG_ORIGIN_X  = 3'd1,
		CFG_ORIGIN_Y  = 3'd2,
		CFG_CELL_SIZE = 3'd3,
		CFG_SLOW      = 3'd4,
		CFG_FAST      = 3'd5
	} cfg_idx_t;

	// one input beat
	typedef struct packed {
		logic        [9:0]  cell_row;
		logic        [9:0]  cell_col;
		logic signed [15:0] vec_x;
		logic signed [15:0] vec_y;
	} in_item_t;

	// one result beat
	typedef struct packed {
		logic signed [15:0] clamped_x;
		logic signed [15:0] clamped_y;
		logic        [14:0] strength;
		logic signed [39:0] tail_x;
		logic signed [39:0] tail_y;
		logic signed [39:0] head_x;
		logic signed [39:0] head_y;
		logic        [7:0]  red;
		logic        [7:0]  green;
		logic        [7:0]  blue;
	} out_item_t;

	// configuration register file
	typedef struct packed {
		logic        [14:0] strength_limit;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic        [23:0] cell_size;
		logic        [23:0] slow_color;
		logic        [23:0] fast_color;
	} cfg_t;

	// classified item held in the queue
	typedef struct packed {
		logic signed [15:0] vec_x;
		logic signed [15:0] vec_y;
		logic        [31:0] sum_sq;
		logic signed [39:0] tail_x;
		logic signed [39:0] tail_y;
	} q_item_t;

endpackage

[rtl/core/vgg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgg_if
// Valid/ready channels of the vector glyph generator: input, result, config.
// ----------------------------------------------------------------------------
interface vgg_in_if;
	import vgg_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vgg_out_if;
	import vgg_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vgg_cfg_if;
	import vgg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

[rtl/core/vgg_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgg_queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module vgg_queue #(
	parameter int DEPTH = vgg_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vgg_pkg::q_item_t wdata,
	output logic             full,
	input  logic             pop,
	output vgg_pkg::q_item_t rdata,
	output logic             nonempty
);
	import vgg_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_item_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

[rtl/core/vgg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgg_front
// Accepts cell beats, saturates indexes, squares the vector and places the
// cell centre, then hands the classified item to the queue.
// ----------------------------------------------------------------------------
module vgg_front #(
	parameter int GRID_ROWS = vgg_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = vgg_pkg::GRID_COLS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  vgg_pkg::cfg_t    cfg,
	vgg_in_if.sink           item,
	output logic             push,
	output vgg_pkg::q_item_t push_data,
	input  logic             full
);
	import vgg_pkg::*;

	logic               v_s1;
	logic signed [15:0] vx_s1;
	logic signed [15:0] vy_s1;
	logic        [30:0] sqx_s1;
	logic        [30:0] sqy_s1;
	logic        [33:0] colp_s1;
	logic        [33:0] rowp_s1;

	logic        [9:0]  row_sat;
	logic        [9:0]  col_sat;
	logic signed [31:0] sqx_full;
	logic signed [31:0] sqy_full;
	logic               load;
	logic        [22:0] half_cell;

	assign item.ready = !v_s1 || !full;
	assign load       = item.valid && item.ready;
	assign push       = v_s1 && !full;

	// clip indexes to the grid
	assign row_sat = (int'(item.data.cell_row) >= GRID_ROWS) ? 10'(GRID_ROWS - 1)
	                                                         : item.data.cell_row;
	assign col_sat = (int'(item.data.cell_col) >= GRID_COLS) ? 10'(GRID_COLS - 1)
	                                                         : item.data.cell_col;

	// squares of the components
	assign sqx_full = item.data.vec_x * item.data.vec_x;
	assign sqy_full = item.data.vec_y * item.data.vec_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (load)
			v_s1 <= 1'b1;
		else if (push)
			v_s1 <= 1'b0;
	end

	// products registered ahead of the queue
	always_ff @(posedge clk) begin
		if (load) begin
			vx_s1   <= item.data.vec_x;
			vy_s1   <= item.data.vec_y;
			sqx_s1  <= sqx_full[30:0];
			sqy_s1  <= sqy_full[30:0];
			colp_s1 <= 34'(col_sat) * 34'(cfg.cell_size);
			rowp_s1 <= 34'(row_sat) * 34'(cfg.cell_size);
		end
	end

	// cell centre and squared length
	assign half_cell = cfg.cell_size[23:1];

	always_comb begin
		push_data.vec_x  = vx_s1;
		push_data.vec_y  = vy_s1;
		push_data.sum_sq = 32'(sqx_s1) + 32'(sqy_s1);
		push_data.tail_x = {{8{cfg.origin_x[31]}}, cfg.origin_x} + {6'b0, colp_s1}
		                   + {17'b0, half_cell};
		push_data.tail_y = {{8{cfg.origin_y[31]}}, cfg.origin_y} - {6'b0, rowp_s1}
		                   - {17'b0, half_cell};
	end

endmodule

[rtl/core/vgg_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgg_sqrt
// Pipelined integer square root of a 32-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module vgg_sqrt #(
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [31:0]   radicand,
	input  logic [TW-1:0] in_tag,
	output logic          out_v,
	output logic [15:0]   root,
	output logic [TW-1:0] out_tag
);

	localparam int NS = 16;

	logic [17:0]   rem_s  [NS];
	logic [15:0]   root_s [NS];
	logic [31:0]   x_s    [NS];
	logic [TW-1:0] tag_s  [NS];
	logic          v_s    [NS];

	for (genvar i = 0; i < NS; i++) begin : g_stage
		logic [17:0]   rem_in;
		logic [15:0]   root_in;
		logic [31:0]   x_in;
		logic [TW-1:0] tag_in;
		logic          v_in;
		logic [17:0]   cat;
		logic [17:0]   trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = radicand;
			assign tag_in  = in_tag;
			assign v_in    = in_v;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign x_in    = x_s[i-1];
			assign tag_in  = tag_s[i-1];
			assign v_in    = v_s[i-1];
		end

		// bring down two bits and try the next root bit
		assign cat   = {rem_in[15:0], x_in[31:30]};
		assign trial = {root_in, 2'b01};
		assign ge    = (cat >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i] <= 1'b0;
			else if (en)
				v_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? (cat - trial) : cat;
				root_s[i] <= {root_in[14:0], ge};
				x_s[i]    <= {x_in[29:0], 2'b00};
				tag_s[i]  <= tag_in;
			end
		end
	end

	assign out_v   = v_s[NS-1];
	assign root    = root_s[NS-1];
	assign out_tag = tag_s[NS-1];

endmodule

[rtl/core/vgg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgg_div
// Pipelined restoring divider, one quotient bit per stage. The top NW-QW
// bits of the numerator must already be below the divisor.
// ----------------------------------------------------------------------------
module vgg_div #(
	parameter int NW = 40,
	parameter int DW = 16,
	parameter int QW = 24,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] in_tag,
	output logic          out_v,
	output logic [QW-1:0] quo,
	output logic [TW-1:0] out_tag
);

	logic [DW:0]   rem_s [QW];
	logic [QW-1:0] lo_s  [QW];
	logic [QW-1:0] q_s   [QW];
	logic [DW-1:0] den_s [QW];
	logic [TW-1:0] tag_s [QW];
	logic          v_s   [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW:0]   rem_in;
		logic [QW-1:0] lo_in;
		logic [QW-1:0] q_in;
		logic [DW-1:0] den_in;
		logic [TW-1:0] tag_in;
		logic          v_in;
		logic [DW:0]   trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in = (DW+1)'(num[NW-1:QW]);
			assign lo_in  = num[QW-1:0];
			assign q_in   = '0;
			assign den_in = den;
			assign tag_in = in_tag;
			assign v_in   = in_v;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign lo_in  = lo_s[i-1];
			assign q_in   = q_s[i-1];
			assign den_in = den_s[i-1];
			assign tag_in = tag_s[i-1];
			assign v_in   = v_s[i-1];
		end

		// shift in one numerator bit and compare against the divisor
		assign trial = {rem_in[DW-1:0], lo_in[QW-1]};
		assign ge    = (trial >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i] <= 1'b0;
			else if (en)
				v_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? (trial - {1'b0, den_in}) : trial;
				lo_s[i]  <= {lo_in[QW-2:0], 1'b0};
				q_s[i]   <= {q_in[QW-2:0], ge};
				den_s[i] <= den_in;
				tag_s[i] <= tag_in;
			end
		end
	end

	assign out_v   = v_s[QW-1];
	assign quo     = q_s[QW-1];
	assign out_tag = tag_s[QW-1];

endmodule

[rtl/core/vgg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgg_back
// Length, clamp, arrow head and colour blend of queued items. The whole
// pipe advances together whenever the result register can move.
// ----------------------------------------------------------------------------
module vgg_back (
	input  logic             clk,
	input  logic             arst_n,
	input  vgg_pkg::cfg_t    cfg,
	input  logic             q_valid,
	input  vgg_pkg::q_item_t q_data,
	output logic             q_pop,
	vgg_out_if.source        result
);
	import vgg_pkg::*;

	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [39:0] tx;
		logic signed [39:0] ty;
	} sq_tag_t;

	typedef struct packed {
		logic               big;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic        [15:0] len;
		logic signed [39:0] tx;
		logic signed [39:0] ty;
	} cl_tag_t;

	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic signed [39:0] tx;
		logic signed [39:0] ty;
	} hd_tag_t;

	logic        en;
	logic [14:0] lim;

	sq_tag_t     sq_tag_in, sq_tag_out;
	logic        sq_v;
	logic [15:0] sq_root;

	logic        v_s1;
	logic [30:0] numx_s1, numy_s1;
	logic [15:0] den_s1;
	cl_tag_t     tag_s1;
	logic        vy_neg_s1;

	cl_tag_t     cl_tag;
	logic        cl_v, cl_vy;
	logic        cl_ny;
	logic [14:0] qx, qy;
	logic [15:0] mx, my;
	logic [15:0] cx_c, cy_c;
	logic [14:0] str_c;

	logic        v_s2;
	logic [39:0] numhx_s2, numhy_s2;
	logic [14:0] str_s2;
	hd_tag_t     tag_s2;

	hd_tag_t     hd_tag;
	logic        hd_v, hy_v, t_v;
	logic        hy_neg;
	logic [14:0] t_str;
	logic [23:0] qhx, qhy, qt;
	logic [39:0] offx, offy;
	logic [8:0]  tfrac;

	logic        out_v_q;
	out_item_t   out_q;

	// magnitude of a Q7.8 component
	function automatic logic [15:0] mag16(logic signed [15:0] v);
		return v[15] ? 16'(-v) : 16'(v);
	endfunction

	// one colour channel blend
	function automatic logic [7:0] blend(logic [7:0] s, logic [7:0] f, logic [8:0] t);
		logic [16:0] a;
		logic [16:0] b;
		logic [17:0] sum;
		a   = 17'(9'd256 - t) * 17'(s);
		b   = 17'(t) * 17'(f);
		sum = 18'(a) + 18'(b);
		return sum[15:8];
	endfunction

	assign en    = !out_v_q || result.ready;
	assign q_pop = en && q_valid;
	assign lim   = (cfg.strength_limit == '0) ? 15'd1 : cfg.strength_limit;

	// vector length
	assign sq_tag_in.vx = q_data.vec_x;
	assign sq_tag_in.vy = q_data.vec_y;
	assign sq_tag_in.tx = q_data.tail_x;
	assign sq_tag_in.ty = q_data.tail_y;

	vgg_sqrt #(.TW($bits(sq_tag_t))) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (q_valid),
		.radicand (q_data.sum_sq),
		.in_tag   (sq_tag_in),
		.out_v    (sq_v),
		.root     (sq_root),
		.out_tag  (sq_tag_out)
	);

	// clamp set-up: scale numerators when the length is over the limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= sq_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1.big <= (sq_root > 16'(lim));
			tag_s1.vx  <= sq_tag_out.vx;
			tag_s1.vy  <= sq_tag_out.vy;
			tag_s1.len <= sq_root;
			tag_s1.tx  <= sq_tag_out.tx;
			tag_s1.ty  <= sq_tag_out.ty;
			vy_neg_s1  <= sq_tag_out.vy[15];
			if (sq_root > 16'(lim)) begin
				numx_s1 <= 31'(mag16(sq_tag_out.vx)) * 31'(lim);
				numy_s1 <= 31'(mag16(sq_tag_out.vy)) * 31'(lim);
				den_s1  <= sq_root;
			end else begin
				numx_s1 <= '0;
				numy_s1 <= '0;
				den_s1  <= 16'd1;
			end
		end
	end

	vgg_div #(.NW(31), .DW(16), .QW(15), .TW($bits(cl_tag_t))) u_div_cx (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s1),
		.num     (numx_s1),
		.den     (den_s1),
		.in_tag  (tag_s1),
		.out_v   (cl_v),
		.quo     (qx),
		.out_tag (cl_tag)
	);

	vgg_div #(.NW(31), .DW(16), .QW(15), .TW(1)) u_div_cy (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s1),
		.num     (numy_s1),
		.den     (den_s1),
		.in_tag  (vy_neg_s1),
		.out_v   (cl_vy),
		.quo     (qy),
		.out_tag (cl_ny)
	);

	// clamped vector and strength
	assign mx    = {1'b0, qx};
	assign my    = {1'b0, qy};
	assign cx_c  = cl_tag.big ? (cl_tag.vx[15] ? 16'd0 - mx : mx) : cl_tag.vx;
	assign cy_c  = cl_tag.big ? (cl_ny ? 16'd0 - my : my) : cl_tag.vy;
	assign str_c = cl_tag.big ? lim : cl_tag.len[14:0];

	// head and colour set-up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= cl_v && cl_vy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numhx_s2  <= 40'(mag16(cx_c)) * 40'(cfg.cell_size);
			numhy_s2  <= 40'(mag16(cy_c)) * 40'(cfg.cell_size);
			str_s2    <= str_c;
			tag_s2.cx <= cx_c;
			tag_s2.cy <= cy_c;
			tag_s2.tx <= cl_tag.tx;
			tag_s2.ty <= cl_tag.ty;
		end
	end

	vgg_div #(.NW(40), .DW(16), .QW(24), .TW($bits(hd_tag_t))) u_div_hx (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s2),
		.num     (numhx_s2),
		.den     ({lim, 1'b0}),
		.in_tag  (tag_s2),
		.out_v   (hd_v),
		.quo     (qhx),
		.out_tag (hd_tag)
	);

	vgg_div #(.NW(40), .DW(16), .QW(24), .TW(1)) u_div_hy (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s2),
		.num     (numhy_s2),
		.den     ({lim, 1'b0}),
		.in_tag  (tag_s2.cy[15]),
		.out_v   (hy_v),
		.quo     (qhy),
		.out_tag (hy_neg)
	);

	// blend weight: strength over limit with 8 fraction bits
	vgg_div #(.NW(40), .DW(16), .QW(24), .TW(15)) u_div_t (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s2),
		.num     (40'({str_s2, 8'b0})),
		.den     ({1'b0, lim}),
		.in_tag  (str_s2),
		.out_v   (t_v),
		.quo     (qt),
		.out_tag (t_str)
	);

	assign offx  = hd_tag.cx[15] ? 40'd0 - 40'(qhx) : 40'(qhx);
	assign offy  = hy_neg ? 40'd0 - 40'(qhy) : 40'(qhy);
	assign tfrac = (qt > 24'd256) ? 9'd256 : qt[8:0];

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (en)
			out_v_q <= hd_v && hy_v && t_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.clamped_x <= hd_tag.cx;
			out_q.clamped_y <= hd_tag.cy;
			out_q.strength  <= t_str;
			out_q.tail_x    <= hd_tag.tx;
			out_q.tail_y    <= hd_tag.ty;
			out_q.head_x    <= hd_tag.tx + offx;
			out_q.head_y    <= hd_tag.ty + offy;
			out_q.red       <= blend(cfg.slow_color[23:16], cfg.fast_color[23:16], tfrac);
			out_q.green     <= blend(cfg.slow_color[15:8], cfg.fast_color[15:8], tfrac);
			out_q.blue      <= blend(cfg.slow_color[7:0], cfg.fast_color[7:0], tfrac);
		end
	end

	assign result.valid = out_v_q;
	assign result.data  = out_q;

endmodule

[rtl/core/vector_glyph_generator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_glyph_generator_unit
// Arrow glyph per grid cell: clamped vector, strength, tail, head and colour.
// ----------------------------------------------------------------------------
// Usage:
//  - item: one beat per cell (row, column, Q7.8 vector), valid/ready.
//  - result: one beat per item, in order, valid/ready.
//  - cfg: register writes (index, wdata), always ready; write only while idle.
//  - Throughput: one cell per cycle while the result side takes beats.
//  - Path from item beat to result valid: front register, queue,
//    16-stage square root, clamp set-up, 15-stage clamp divider,
//    head set-up, 24-stage head and weight dividers, result register.
//  - Back pressure: the back pipe freezes while a result waits; the 4-entry
//    queue keeps the front taking beats until it fills.
//  - Reset: clears all valid flags and the queue and loads register defaults
//    (limit 1.0, origin 0, cell size 1.0, blue to red).
// ----------------------------------------------------------------------------
module vector_glyph_generator_unit #(
	parameter int GRID_ROWS = vgg_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = vgg_pkg::GRID_COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	vgg_in_if.sink     item,
	vgg_out_if.source  result,
	vgg_cfg_if.sink    cfg
);
	import vgg_pkg::*;

	cfg_t    cfg_q;
	logic    push, full, pop, nonempty;
	q_item_t push_data, pop_data;

	// register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strength_limit <= LIMIT_RST;
			cfg_q.origin_x       <= '0;
			cfg_q.origin_y       <= '0;
			cfg_q.cell_size      <= CELL_SIZE_RST;
			cfg_q.slow_color     <= SLOW_RST;
			cfg_q.fast_color     <= FAST_RST;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_LIMIT:     cfg_q.strength_limit <= cfg.wdata[14:0];
				CFG_ORIGIN_X:  cfg_q.origin_x       <= cfg.wdata;
				CFG_ORIGIN_Y:  cfg_q.origin_y       <= cfg.wdata;
				CFG_CELL_SIZE: cfg_q.cell_size      <= cfg.wdata[23:0];
				CFG_SLOW:      cfg_q.slow_color     <= cfg.wdata[23:0];
				CFG_FAST:      cfg_q.fast_color     <= cfg.wdata[23:0];
				default: ;
			endcase
		end
	end

	vgg_front #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (item),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	vgg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (push_data),
		.full     (full),
		.pop      (pop),
		.rdata    (pop_data),
		.nonempty (nonempty)
	);

	vgg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (nonempty),
		.q_data  (pop_data),
		.q_pop   (pop),
		.result  (result)
	);

endmodule

[rtl/core/vgg_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgg_chk
// Port-level checks of the vector glyph generator, bound to the top level.
// ----------------------------------------------------------------------------
module vgg_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic res_valid,
	input logic res_ready
);

	logic [7:0] inflight_q;

	// count of items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else if ((in_valid && in_ready) && !(res_valid && res_ready))
			inflight_q <= inflight_q + 1'b1;
		else if (!(in_valid && in_ready) && (res_valid && res_ready))
			inflight_q <= inflight_q - 1'b1;
	end

	// a stalled result beat stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat withdrawn under stall");

	// no result without an item behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> inflight_q != 8'd0)
		else $error("result beat with no item in flight");

	// an open result side drains the queue so the input opens up
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready && $past(res_ready) && $past(arst_n) |-> in_ready)
		else $error("input stalled while result side is open");

endmodule

bind vector_glyph_generator_unit vgg_chk u_vgg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.res_valid (result.valid),
	.res_ready (result.ready)
);

[tb/tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_if
// Channel interfaces come with the block; this file keeps the shared record
// types of the bench that sit next to them.
// ----------------------------------------------------------------------------
package tb_glyph_pkg;
	import vgg_pkg::*;

	// one directed stimulus row
	typedef struct {
		in_item_t  vec_in;
		bit        known;
		out_item_t glyph;
	} stim_row_t;
endpackage

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the vector glyph generator against an in-bench predictor of the
// clamp, arrow geometry and colour blend, under random bursts and stalls.
// ----------------------------------------------------------------------------
module tb;
	import vgg_pkg::*;
	import tb_glyph_pkg::*;

	localparam int LATENCY = 59;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vgg_in_if  item_ch();
	vgg_out_if result_ch();
	vgg_cfg_if cfg_ch();

	vector_glyph_generator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.item(item_ch.sink), .result(result_ch.source), .cfg(cfg_ch.sink)
	);

	always #5 clk = ~clk;

	// predictor copy of the register file
	logic [14:0] m_limit;
	logic signed [31:0] m_org_x, m_org_y;
	logic [23:0] m_cell, m_slow, m_fast;

	out_item_t glyph_q[$];
	int mismatches = 0;
	int glyphs_seen = 0;
	bit stall_on = 1'b0;

	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint trunc_scale(longint v, longint num, longint den);
		longint mag, q;
		mag = (v < 0) ? -v : v;
		q = (mag * num) / den;
		return (v < 0) ? -q : q;
	endfunction

	function automatic out_item_t glyph_of(in_item_t c);
		out_item_t g;
		longint row, col, vx, vy, lim, len, str, cx, cy, tx, ty, t, cs;
		lim = (m_limit == 0) ? 1 : m_limit;
		cs = m_cell;
		row = (c.cell_row >= 64) ? 63 : c.cell_row;
		col = (c.cell_col >= 64) ? 63 : c.cell_col;
		vx = c.vec_x;
		vy = c.vec_y;
		len = isqrt(vx * vx + vy * vy);
		if (len > lim) begin
			cx = trunc_scale(vx, lim, len);
			cy = trunc_scale(vy, lim, len);
			str = lim;
		end else begin
			cx = vx;
			cy = vy;
			str = len;
		end
		tx = longint'(m_org_x) + col * cs + (cs >> 1);
		ty = longint'(m_org_y) - row * cs - (cs >> 1);
		t = (str * 256) / lim;
		if (t > 256) t = 256;
		g.clamped_x = cx[15:0];
		g.clamped_y = cy[15:0];
		g.strength = str[14:0];
		g.tail_x = tx[39:0];
		g.tail_y = ty[39:0];
		g.head_x = 40'(tx + trunc_scale(cx, cs, 2 * lim));
		g.head_y = 40'(ty + trunc_scale(cy, cs, 2 * lim));
		g.red   = 8'(((256 - t) * m_slow[23:16] + t * m_fast[23:16]) >> 8);
		g.green = 8'(((256 - t) * m_slow[15:8] + t * m_fast[15:8]) >> 8);
		g.blue  = 8'(((256 - t) * m_slow[7:0] + t * m_fast[7:0]) >> 8);
		return g;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_LIMIT:     m_limit = val[14:0];
			CFG_ORIGIN_X:  m_org_x = val;
			CFG_ORIGIN_Y:  m_org_y = val;
			CFG_CELL_SIZE: m_cell = val[23:0];
			CFG_SLOW:      m_slow = val[23:0];
			CFG_FAST:      m_fast = val[23:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// sender burst state
	int burst_left = 0;

	task automatic send_cell(in_item_t c, bit known, out_item_t g);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_ch.valid <= 1'b1;
		item_ch.data <= c;
		do @(posedge clk); while (!item_ch.ready);
		glyph_q = {glyph_q, known ? g : glyph_of(c)};
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		while (glyph_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic in_item_t rand_cell();
		in_item_t c;
		c.cell_row = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
		                                       : 10'($urandom_range(0, 63));
		c.cell_col = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
		                                       : 10'($urandom_range(0, 63));
		case ($urandom_range(0, 3))
			0: begin
				c.vec_x = 16'($urandom);
				c.vec_y = 16'($urandom);
			end
			1: begin
				c.vec_x = 16'(int'($urandom_range(0, 1023)) - 512);
				c.vec_y = 16'(int'($urandom_range(0, 1023)) - 512);
			end
			2: begin
				c.vec_x = 16'(int'($urandom_range(0, 63)) - 32);
				c.vec_y = 16'(int'($urandom_range(0, 63)) - 32);
			end
			default: begin
				c.vec_x = 16'd0;
				c.vec_y = 16'($urandom);
			end
		endcase
		return c;
	endfunction

	// directed cells at reset settings
	function automatic stim_row_t mk(logic [9:0] r, logic [9:0] c, logic [15:0] x,
			logic [15:0] y, bit known, out_item_t g);
		stim_row_t s;
		s.vec_in = '{cell_row: r, cell_col: c, vec_x: x, vec_y: y};
		s.known = known;
		s.glyph = g;
		return s;
	endfunction

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
		end
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			glyphs_seen++;
			if (glyph_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected glyph beat: %p", result_ch.data);
			end else begin
				out_item_t e;
				e = glyph_q.pop_front();
				if (e !== result_ch.data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("glyph mismatch\n exp %p\n got %p", e, result_ch.data);
				end
			end
		end
	end

	// stall pattern toggles at random intervals
	always begin
		repeat ($urandom_range(50, 400)) @(posedge clk);
		stall_on = ~stall_on;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		out_item_t g;
		in_item_t c;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_LIMIT;
		cfg_ch.wdata = '0;
		m_limit = LIMIT_RST; m_org_x = 0; m_org_y = 0;
		m_cell = CELL_SIZE_RST; m_slow = SLOW_RST; m_fast = FAST_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero vector at cell 0: tail at half a cell, head on tail, slow colour
		g = '0;
		g.tail_x = 40'sd32768; g.tail_y = -40'sd32768;
		g.head_x = 40'sd32768; g.head_y = -40'sd32768;
		g.blue = 8'd255;
		rows = {rows, mk(10'd0, 10'd0, 16'd0, 16'd0, 1'b1, g)};
		// full-length vector along x: fast colour, head half a cell right
		g.clamped_x = 16'sd256; g.strength = 15'd256;
		g.head_x = 40'sd65536; g.red = 8'd255; g.blue = 8'd0;
		rows = {rows, mk(10'd0, 10'd0, 16'sd256, 16'd0, 1'b1, g)};
		rows = {rows, mk(10'd63, 10'd63, 16'h7fff, 16'h7fff, 1'b0, g)};
		rows = {rows, mk(10'd1023, 10'd1023, 16'h8000, 16'h8000, 1'b0, g)};
		rows = {rows, mk(10'd64, 10'd0, 16'h8000, 16'h7fff, 1'b0, g)};
		rows = {rows, mk(10'd0, 10'd64, 16'd0, 16'h8000, 1'b0, g)};
		rows = {rows, mk(10'h2aa, 10'h155, 16'h5555, 16'haaaa, 1'b0, g)};
		rows = {rows, mk(10'h155, 10'h2aa, 16'haaaa, 16'h5555, 1'b0, g)};
		rows = {rows, mk(10'd5, 10'd7, 16'sd255, 16'd0, 1'b0, g)};
		rows = {rows, mk(10'd5, 10'd7, -16'sd257, 16'sd1, 1'b0, g)};
		rows = {rows, mk(10'd2, 10'd3, -16'sd1, -16'sd1, 1'b0, g)};
		foreach (rows[i]) send_cell(rows[i].vec_in, rows[i].known, rows[i].glyph);
		drain();

		// several register settings, extremes included
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_LIMIT, 32'd0); write_reg(CFG_CELL_SIZE, 32'd1);
					write_reg(CFG_ORIGIN_X, 32'h8000_0000);
					write_reg(CFG_ORIGIN_Y, 32'h7fff_ffff);
					write_reg(CFG_SLOW, 32'd0); write_reg(CFG_FAST, 32'h00ff_ffff);
				end
				1: begin
					write_reg(CFG_LIMIT, 32'h0000_7fff);
					write_reg(CFG_CELL_SIZE, 32'h00ff_ffff);
					write_reg(CFG_ORIGIN_X, 32'h7fff_ffff);
					write_reg(CFG_ORIGIN_Y, 32'h8000_0000);
					write_reg(CFG_SLOW, 32'h00ff_ffff); write_reg(CFG_FAST, 32'd0);
				end
				2: write_reg(CFG_LIMIT, 32'd1);
				default: begin
					write_reg(CFG_LIMIT, $urandom_range(1, 32767) >> $urandom_range(0, 8));
					write_reg(CFG_ORIGIN_X, $urandom);
					write_reg(CFG_ORIGIN_Y, $urandom);
					write_reg(CFG_CELL_SIZE, $urandom_range(1, 32'h00ff_ffff));
					write_reg(CFG_SLOW, $urandom);
					write_reg(CFG_FAST, $urandom);
				end
			endcase
			for (int k = 0; k < 240; k++) begin
				c = rand_cell();
				send_cell(c, 1'b0, g);
				// one hold-off until everything is back
				if (ph == 3 && k == 100) begin
					item_ch.valid <= 1'b0;
					burst_left = 0;
					while (glyph_q.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		if (mismatches == 0 && glyph_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

[files.f]
rtl/core/vgg_pkg.sv
rtl/core/vgg_if.sv
rtl/core/vgg_queue.sv
rtl/core/vgg_front.sv
rtl/core/vgg_sqrt.sv
rtl/core/vgg_div.sv
rtl/core/vgg_back.sv
rtl/core/vector_glyph_generator_unit.sv
rtl/core/vgg_chk.sv
tb/tb_if.sv
tb/tb.sv
